>>> rtl/dpbg_pkg.sv
// Package for the DCC packet bit generator: request kind codes, field widths
// and the packet and timing structs that pass between the modules. No dependencies.
package dpbg_pkg;

    localparam int unsigned MAX_BYTES = 7;   // up to six packet bytes plus the checksum

    localparam logic [3:0] REQ_IDLE       = 4'd0;
    localparam logic [3:0] REQ_RESET      = 4'd1;
    localparam logic [3:0] REQ_STOP       = 4'd2;
    localparam logic [3:0] REQ_SPEED28    = 4'd3;
    localparam logic [3:0] REQ_SPEED128   = 4'd4;
    localparam logic [3:0] REQ_FUNC_RAW   = 4'd5;
    localparam logic [3:0] REQ_FG1        = 4'd6;
    localparam logic [3:0] REQ_FG2        = 4'd7;
    localparam logic [3:0] REQ_OPS_CV_WR  = 4'd8;
    localparam logic [3:0] REQ_SVC_WRITE  = 4'd9;
    localparam logic [3:0] REQ_SVC_VERIFY = 4'd10;

    localparam logic [1:0] CFG_ONE_HP      = 2'd0;
    localparam logic [1:0] CFG_ZERO_HP     = 2'd1;
    localparam logic [1:0] CFG_PREAMBLE    = 2'd2;
    localparam logic [1:0] CFG_SVC_PREAMBLE = 2'd3;

    localparam logic [7:0] RST_ONE_HP       = 8'd58;
    localparam logic [7:0] RST_ZERO_HP      = 8'd100;
    localparam logic [4:0] RST_PREAMBLE     = 5'd12;
    localparam logic [4:0] RST_SVC_PREAMBLE = 5'd20;

    localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;
    localparam logic [13:0] LONG_ADDR_MIN  = 14'd128;
    localparam logic [13:0] LONG_ADDR_MAX  = 14'd10239;
    localparam logic [7:0]  SPEED28_MAX    = 8'd28;
    localparam logic [7:0]  SPEED128_MAX   = 8'd127;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;      // byte 0 is sent first
        logic [2:0]                last_idx;   // index of the checksum byte
        logic                      lone_zero;  // extra zero after the preamble
        logic [4:0]                preamble;   // already clamped to at least one
    } dpbg_pkt_t;

    typedef struct packed {
        logic [7:0] one_hp;
        logic [7:0] zero_hp;
    } dpbg_timing_t;

endpackage

>>> rtl/dpbg_encoder.sv
// Combinational packet builder: turns one request into its packet bytes,
// checksum and preamble length. Depends on dpbg_pkg.
module dpbg_encoder (
    input  logic [3:0]          req_type,
    input  logic [13:0]         address,
    input  logic                direction,
    input  logic [7:0]          speed,
    input  logic [7:0]          data_byte,
    input  logic [9:0]          cv_number,
    input  logic [1:0]          stop_kind,
    input  logic [4:0]          preamble_length,
    input  logic [4:0]          service_preamble_length,
    output logic                pkt_valid,
    output dpbg_pkg::dpbg_pkt_t pkt
);

    logic             uses_addr;
    logic [1:0]       n_addr;
    logic [1:0]       n_cmd;
    logic [1:0][7:0]  addr_b;
    logic [2:0][7:0]  cmd_b;
    logic [5:0][7:0]  body;
    logic [2:0]       nb;
    logic [7:0]       ck;
    logic [4:0]       s28;
    logic [6:0]       s128;
    logic [9:0]       cv_dec;
    logic [4:0]       pre;
    logic [7:0]       stop_pat;

    always_comb begin
        pkt_valid = (req_type <= dpbg_pkg::REQ_SVC_VERIFY);
        uses_addr = (req_type >= dpbg_pkg::REQ_SPEED28) && (req_type <= dpbg_pkg::REQ_OPS_CV_WR);

        addr_b = '0;
        n_addr = 2'd0;
        pkt.lone_zero = 1'b0;
        if (uses_addr) begin
            if (address >= 14'd1 && address <= dpbg_pkg::SHORT_ADDR_MAX) begin
                n_addr    = 2'd1;
                addr_b[0] = address[7:0];
            end else if (address >= dpbg_pkg::LONG_ADDR_MIN
                         && address <= dpbg_pkg::LONG_ADDR_MAX) begin
                n_addr    = 2'd2;
                addr_b[0] = {2'b11, address[13:8]};
                addr_b[1] = address[7:0];
            end else begin
                pkt.lone_zero = 1'b1;
            end
        end

        // 28-step speed: saturate, then nonzero steps move up by three.
        s28 = (speed > dpbg_pkg::SPEED28_MAX) ? 5'd28 : speed[4:0];
        if (s28 != 5'd0) begin
            s28 = s28 + 5'd3;
        end
        s128   = (speed > dpbg_pkg::SPEED128_MAX) ? 7'd127 : speed[6:0];
        cv_dec = cv_number - 10'd1;
        stop_pat = (stop_kind == 2'd0) ? 8'h10 : (stop_kind == 2'd1) ? 8'h01 : 8'h11;

        cmd_b = '0;
        n_cmd = 2'd0;
        pre   = preamble_length;
        case (req_type)
            dpbg_pkg::REQ_IDLE: begin
                n_cmd = 2'd2; cmd_b[0] = 8'hFF; cmd_b[1] = 8'h00;
            end
            dpbg_pkg::REQ_RESET: begin
                n_cmd = 2'd2;
            end
            dpbg_pkg::REQ_STOP: begin
                n_cmd = 2'd2; cmd_b[1] = 8'h60 | stop_pat;
            end
            dpbg_pkg::REQ_SPEED28: begin
                n_cmd = 2'd1; cmd_b[0] = {2'b01, direction, s28[0], s28[4:1]};
            end
            dpbg_pkg::REQ_SPEED128: begin
                n_cmd = 2'd2; cmd_b[0] = 8'h3F; cmd_b[1] = {direction, s128};
            end
            dpbg_pkg::REQ_FUNC_RAW: begin
                n_cmd = 2'd1; cmd_b[0] = data_byte;
            end
            dpbg_pkg::REQ_FG1: begin
                n_cmd = 2'd1; cmd_b[0] = {3'b100, data_byte[4:0]};
            end
            dpbg_pkg::REQ_FG2: begin
                n_cmd = 2'd1; cmd_b[0] = {3'b101, data_byte[4:0]};
            end
            dpbg_pkg::REQ_OPS_CV_WR: begin
                n_cmd = 2'd3;
                cmd_b[0] = {6'b111011, cv_dec[9:8]};
                cmd_b[1] = cv_dec[7:0];
                cmd_b[2] = data_byte;
            end
            dpbg_pkg::REQ_SVC_WRITE, dpbg_pkg::REQ_SVC_VERIFY: begin
                n_cmd = 2'd3;
                pre   = service_preamble_length;
                cmd_b[0] = {((req_type == dpbg_pkg::REQ_SVC_WRITE) ? 6'b011111 : 6'b011101),
                            cv_number[9:8]};
                cmd_b[1] = cv_number[7:0];
                cmd_b[2] = data_byte;
            end
            default: begin
                n_cmd = 2'd0;
            end
        endcase
        pkt.preamble = (pre == 5'd0) ? 5'd1 : pre;

        // Idle, reset and stop carry their fixed address byte as the first command byte.
        body = '0;
        unique case (n_addr)
            2'd1: begin
                body[0] = addr_b[0];
                body[3:1] = cmd_b;
            end
            2'd2: begin
                body[1:0] = addr_b;
                body[4:2] = cmd_b;
            end
            default: begin
                body[2:0] = cmd_b;
            end
        endcase
        nb = {1'b0, n_addr} + {1'b0, n_cmd};

        ck = '0;
        for (int i = 0; i < 6; i++) begin
            ck = ck ^ body[i];
        end

        pkt.bytes = {8'h00, body};
        for (int i = 0; i < dpbg_pkg::MAX_BYTES; i++) begin
            if (3'(i) == nb) begin
                pkt.bytes[i] = ck;
            end
        end
        pkt.last_idx = nb;
    end

endmodule

>>> rtl/dpbg_serializer.sv
// Bit serializer: walks one held packet and emits preamble, start bits, data
// bits and the end bit into a registered output stage. Depends on dpbg_pkg.
module dpbg_serializer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pkt_valid,
    input  dpbg_pkg::dpbg_pkt_t    pkt,
    output logic                   pkt_take,
    input  dpbg_pkg::dpbg_timing_t timing,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,
    output logic                   m_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRE  = 3'd1;
    localparam logic [2:0] ST_LONE = 3'd2;
    localparam logic [2:0] ST_BYTE = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          byte_idx_reg, byte_idx_next;
    logic [3:0]          bit_idx_reg, bit_idx_next;
    dpbg_pkg::dpbg_pkt_t cur_reg, cur_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_bit_reg, out_bit_next;
    logic [4:0]          out_rep_reg, out_rep_next;
    logic                out_last_reg, out_last_next;
    logic                advance;
    logic                emit;
    logic [7:0]          cur_byte;
    logic [2:0]          bit_sel;
    logic [7:0]          out_hp;

    assign advance  = !out_valid_reg || m_tready;
    assign cur_byte = cur_reg.bytes[byte_idx_reg];
    assign bit_sel  = 3'(4'd8 - bit_idx_reg);

    always_comb begin
        state_next     = state_reg;
        byte_idx_next  = byte_idx_reg;
        bit_idx_next   = bit_idx_reg;
        cur_next       = cur_reg;
        out_bit_next   = out_bit_reg;
        out_rep_next   = out_rep_reg;
        out_last_next  = out_last_reg;
        pkt_take       = 1'b0;
        emit           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (pkt_valid) begin
                    pkt_take   = 1'b1;
                    cur_next   = pkt;
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                if (advance) begin
                    emit          = 1'b1;
                    out_bit_next  = 1'b1;
                    out_rep_next  = cur_reg.preamble;
                    out_last_next = 1'b0;
                    byte_idx_next = '0;
                    bit_idx_next  = '0;
                    state_next    = cur_reg.lone_zero ? ST_LONE : ST_BYTE;
                end
            end
            ST_LONE: begin
                if (advance) begin
                    emit          = 1'b1;
                    out_bit_next  = 1'b0;
                    out_rep_next  = 5'd1;
                    out_last_next = 1'b0;
                    state_next    = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (advance) begin
                    // Bit position zero is the start bit ahead of each byte.
                    emit          = 1'b1;
                    out_bit_next  = (bit_idx_reg == 4'd0) ? 1'b0 : cur_byte[bit_sel];
                    out_rep_next  = 5'd1;
                    out_last_next = 1'b0;
                    if (bit_idx_reg == 4'd8) begin
                        bit_idx_next = '0;
                        if (byte_idx_reg == cur_reg.last_idx) begin
                            state_next = ST_END;
                        end else begin
                            byte_idx_next = byte_idx_reg + 3'd1;
                        end
                    end else begin
                        bit_idx_next = bit_idx_reg + 4'd1;
                    end
                end
            end
            ST_END: begin
                if (advance) begin
                    emit          = 1'b1;
                    out_bit_next  = 1'b1;
                    out_rep_next  = 5'd1;
                    out_last_next = 1'b1;
                    if (pkt_valid) begin
                        pkt_take   = 1'b1;
                        cur_next   = pkt;
                        state_next = ST_PRE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        byte_idx_reg <= byte_idx_next;
        bit_idx_reg  <= bit_idx_next;
        cur_reg      <= cur_next;
        out_bit_reg  <= out_bit_next;
        out_rep_reg  <= out_rep_next;
        out_last_reg <= out_last_next;
    end

    // Half-periods follow registers the user must change only while idle.
    always_comb begin
        out_hp = out_bit_reg ? timing.one_hp : timing.zero_hp;
        if (out_hp == 8'd0) begin
            out_hp = 8'd1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_hp, out_rep_reg, out_bit_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/dcc_packet_bit_generator_unit.sv
// Top level of the DCC packet bit generator: configuration registers, the
// one-packet holding register, encoder and serializer. Depends on dpbg_pkg.
//
// One request transaction produces the whole track bit sequence of a DCC packet,
// one result transaction per clock while m_tready stays high: a single preamble
// result with its repeat count, an extra zero for an operations packet with an
// omitted address, nine results (start bit and eight data bits) per packet byte
// including the checksum, and the end bit marked by m_tlast. That is 9*B+2 or
// 9*B+3 results for B bytes, so 21 to 56 results per packet. The encoded packet
// waits in a holding register, so the next request is taken while the previous
// packet is still being sent and the serializer moves straight from one end
// bit to the next preamble. Unknown request kinds are accepted and produce no
// results.
module dcc_packet_bit_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[3:0], address[17:4], direction[18], speed[26:19], data_byte[34:27],
    // cv_number[44:35], stop_kind[46:45], zero[47]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bit_value[0], repeat_count[5:1], half_period[13:6], zero[15:14]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]             one_hp_reg;
    logic [7:0]             zero_hp_reg;
    logic [4:0]             preamble_reg;
    logic [4:0]             svc_preamble_reg;
    logic                   enc_valid;
    dpbg_pkg::dpbg_pkt_t    enc_pkt;
    logic                   hold_valid_reg, hold_valid_next;
    dpbg_pkg::dpbg_pkt_t    hold_pkt_reg;
    logic                   pkt_take;
    logic                   s_accept;
    dpbg_pkg::dpbg_timing_t timing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_hp_reg       <= dpbg_pkg::RST_ONE_HP;
            zero_hp_reg      <= dpbg_pkg::RST_ZERO_HP;
            preamble_reg     <= dpbg_pkg::RST_PREAMBLE;
            svc_preamble_reg <= dpbg_pkg::RST_SVC_PREAMBLE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dpbg_pkg::CFG_ONE_HP:       one_hp_reg       <= cfg_wdata;
                dpbg_pkg::CFG_ZERO_HP:      zero_hp_reg      <= cfg_wdata;
                dpbg_pkg::CFG_PREAMBLE:     preamble_reg     <= cfg_wdata[4:0];
                dpbg_pkg::CFG_SVC_PREAMBLE: svc_preamble_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    dpbg_encoder u_encoder (
        .req_type                (s_tdata[3:0]),
        .address                 (s_tdata[17:4]),
        .direction               (s_tdata[18]),
        .speed                   (s_tdata[26:19]),
        .data_byte               (s_tdata[34:27]),
        .cv_number               (s_tdata[44:35]),
        .stop_kind               (s_tdata[46:45]),
        .preamble_length         (preamble_reg),
        .service_preamble_length (svc_preamble_reg),
        .pkt_valid               (enc_valid),
        .pkt                     (enc_pkt)
    );

    assign s_tready = !hold_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (pkt_take) begin
            hold_valid_next = 1'b0;
        end
        if (s_accept) begin
            hold_valid_next = enc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        if (s_accept) begin
            hold_pkt_reg <= enc_pkt;
        end
    end

    assign timing.one_hp  = one_hp_reg;
    assign timing.zero_hp = zero_hp_reg;

    dpbg_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pkt_valid (hold_valid_reg),
        .pkt       (hold_pkt_reg),
        .pkt_take  (pkt_take),
        .timing    (timing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/dpbg_checker.sv
// Port-level checker for the DCC packet bit generator, attached to the top
// level by the bind statement at the end. No package dependencies.
module dpbg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The packet end bit is a single one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[0] == 1'b1 && m_tdata[5:1] == 5'd1)
        else $error("end bit is not a single one");

    // Only the preamble repeats, and the preamble is ones.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:1] != 5'd1 |-> m_tdata[0] == 1'b1 && !m_tlast)
        else $error("repeated bit that is not a preamble");

    // The bit after a packet end is the next preamble, never a data bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata[0] == 1'b1 && !m_tlast)
        else $error("packet does not start with a preamble");

    // Reset empties the result stage.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind dcc_packet_bit_generator_unit dpbg_checker u_dpbg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
